@@ rtl/sgf_pkg.sv @@
package sgf_pkg;

  localparam int VAL_W  = 24;          // sample and result value
  localparam int CNT_W  = 6;           // pending run count
  localparam int DEN_W  = CNT_W + 1;   // run length + 1, up to 64
  localparam int PROD_W = 31;          // (end - start) * k, signed
  localparam int QUO_W  = VAL_W + 1;   // signed quotient, |q| <= |end - start|
  localparam int STEP_W = $clog2(PROD_W);

  typedef struct packed {
    logic                     start;
    logic signed [PROD_W-1:0] dividend;
    logic [DEN_W-1:0]         divisor;
  } div_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [QUO_W-1:0] quot;
  } div_rsp_t;

endpackage

@@ rtl/sgf_div.sv @@
// Restoring divider, one quotient bit per cycle, truncates toward zero.
module sgf_div (
  input  logic              clk,
  input  logic              rst_n,
  input  sgf_pkg::div_req_t req,
  output sgf_pkg::div_rsp_t rsp
);

  logic                             busy_r, busy_nxt;
  logic                             done_r, done_nxt;
  logic [sgf_pkg::STEP_W-1:0]       cnt_r, cnt_nxt;
  logic [sgf_pkg::PROD_W-1:0]       dvd_r, dvd_nxt;
  logic [sgf_pkg::DEN_W-1:0]        rem_r, rem_nxt;
  logic [sgf_pkg::DEN_W-1:0]        den_r, den_nxt;
  logic                             neg_r, neg_nxt;
  logic signed [sgf_pkg::QUO_W-1:0] quot_r, quot_nxt;

  logic [sgf_pkg::DEN_W:0]    rem_sh;
  logic [sgf_pkg::DEN_W:0]    rem_sub;
  logic                       ge;
  logic [sgf_pkg::PROD_W-1:0] dvd_step;
  logic [sgf_pkg::PROD_W-1:0] mag_in;
  logic [sgf_pkg::PROD_W-1:0] q_signed;

  always_comb begin
    rem_sh   = {rem_r, dvd_r[sgf_pkg::PROD_W-1]};
    rem_sub  = rem_sh - {1'b0, den_r};
    ge       = (rem_sh >= {1'b0, den_r});
    dvd_step = {dvd_r[sgf_pkg::PROD_W-2:0], ge};
    q_signed = neg_r ? (~dvd_step + 1'b1) : dvd_step;
    mag_in   = req.dividend[sgf_pkg::PROD_W-1] ? (~req.dividend + 1'b1) : req.dividend;
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    quot_nxt = quot_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = mag_in;
      rem_nxt  = '0;
      den_nxt  = req.divisor;
      neg_nxt  = req.dividend[sgf_pkg::PROD_W-1];
    end else if (busy_r) begin
      dvd_nxt = dvd_step;
      rem_nxt = ge ? rem_sub[sgf_pkg::DEN_W-1:0] : rem_sh[sgf_pkg::DEN_W-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == sgf_pkg::STEP_W'(sgf_pkg::PROD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        quot_nxt = q_signed[sgf_pkg::QUO_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r  <= cnt_nxt;
    dvd_r  <= dvd_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    neg_r  <= neg_nxt;
    quot_r <= quot_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

endmodule

@@ rtl/series_gap_linear_fill.sv @@
// Channel | Dir | tdata          | tuser                                | tlast
// in_     | in  | [23:0] sample  | [0] valid_req                        | series_end
// out_    | out | [23:0] value   | [0] filled [1] gap_overflow [2] s.l. | run_last
//
// One item at a time; in_tready is high only while the sequencer is idle.
// A missing sample that only extends the run emits nothing.
// Each interpolated fill is a divider start, 31 steps of the serial divider,
// finish and emit. Hold fills and the sample itself take 1 cycle each,
// after the accepting cycle.
// A stalled out_tready holds the sequencer; reset (rst_n low, synchronous)
// clears the series state and drops out_tvalid.
module series_gap_linear_fill #(
  parameter int MAX_GAP = 63   // 1..63
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [23:0] sample
  input  logic        in_tuser,   // [0] valid_req
  input  logic        in_tlast,   // series_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [23:0] value
  output logic [2:0]  out_tuser,  // [0] filled, [1] gap_overflow, [2] series_last
  output logic        out_tlast   // run_last
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DSTART = 5'b00010,
    S_DIV    = 5'b00100,
    S_WAIT   = 5'b01000,
    S_SAMPLE = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // series state
  logic signed [sgf_pkg::VAL_W-1:0] last_r, last_nxt;
  logic                             seen_r, seen_nxt;
  logic [sgf_pkg::CNT_W-1:0]        pend_r, pend_nxt;

  // current item
  logic signed [sgf_pkg::VAL_W-1:0]  s_r, s_nxt;
  logic signed [sgf_pkg::VAL_W-1:0]  base_r, base_nxt;
  logic signed [sgf_pkg::VAL_W-1:0]  val_r, val_nxt;
  logic signed [sgf_pkg::QUO_W-1:0]  diff_r, diff_nxt;
  logic signed [sgf_pkg::PROD_W-1:0] prod_r, prod_nxt;
  logic [sgf_pkg::DEN_W-1:0]         den_r, den_nxt;
  logic [sgf_pkg::DEN_W-1:0]         k_r, k_nxt;
  logic [sgf_pkg::DEN_W-1:0]         nfill_r, nfill_nxt;
  logic                              interp_r, interp_nxt;
  logic                              smp_r, smp_nxt;
  logic                              ovf_r, ovf_nxt;
  logic                              end_r, end_nxt;

  // output register
  logic                             ov_r, ov_nxt;
  logic signed [sgf_pkg::VAL_W-1:0] ovalue_r, ovalue_nxt;
  logic                             ofill_r, ofill_nxt;
  logic                             oovf_r, oovf_nxt;
  logic                             orl_r, orl_nxt;
  logic                             osl_r, osl_nxt;

  sgf_pkg::div_req_t div_req;
  sgf_pkg::div_rsp_t div_rsp;

  logic                             in_fire;
  logic                             out_free;
  logic signed [sgf_pkg::VAL_W-1:0] s_in;
  logic signed [sgf_pkg::VAL_W-1:0] hold;
  logic signed [sgf_pkg::QUO_W-1:0] interp_sum;
  logic [sgf_pkg::DEN_W-1:0]        pend_p1;
  logic                             fill_last;

  sgf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid & in_tready;
  assign out_free  = ~ov_r | out_tready;
  assign s_in      = in_tdata;
  assign hold      = seen_r ? last_r : '0;
  assign pend_p1   = {1'b0, pend_r} + 1'b1;
  assign fill_last = (k_r == nfill_r) & ~smp_r;
  assign interp_sum = {base_r[sgf_pkg::VAL_W-1], base_r} + div_rsp.quot;

  always_comb begin
    state_nxt  = state_r;
    last_nxt   = last_r;
    seen_nxt   = seen_r;
    pend_nxt   = pend_r;
    s_nxt      = s_r;
    base_nxt   = base_r;
    val_nxt    = val_r;
    diff_nxt   = diff_r;
    prod_nxt   = prod_r;
    den_nxt    = den_r;
    k_nxt      = k_r;
    nfill_nxt  = nfill_r;
    interp_nxt = interp_r;
    smp_nxt    = smp_r;
    ovf_nxt    = ovf_r;
    end_nxt    = end_r;
    ov_nxt     = ov_r & ~out_tready;
    ovalue_nxt = ovalue_r;
    ofill_nxt  = ofill_r;
    oovf_nxt   = oovf_r;
    orl_nxt    = orl_r;
    osl_nxt    = osl_r;
    div_req.start    = 1'b0;
    div_req.dividend = prod_r;
    div_req.divisor  = den_r;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          k_nxt   = sgf_pkg::DEN_W'(1);
          s_nxt   = s_in;
          end_nxt = in_tlast;
          if (!in_tuser) begin
            interp_nxt = 1'b0;
            smp_nxt    = 1'b0;
            val_nxt    = hold;
            nfill_nxt  = pend_p1;
            if (in_tlast) begin
              // trailing run: holds, then the series starts over
              ovf_nxt   = 1'b0;
              last_nxt  = '0;
              seen_nxt  = 1'b0;
              pend_nxt  = '0;
              state_nxt = S_WAIT;
            end else if (pend_r == sgf_pkg::CNT_W'(MAX_GAP)) begin
              ovf_nxt   = 1'b1;
              pend_nxt  = '0;
              state_nxt = S_WAIT;
            end else begin
              pend_nxt = pend_r + 1'b1;
            end
          end else begin
            ovf_nxt    = 1'b0;
            smp_nxt    = 1'b1;
            nfill_nxt  = {1'b0, pend_r};
            den_nxt    = pend_p1;
            base_nxt   = last_r;
            val_nxt    = s_in;   // leading run takes the first valid value
            interp_nxt = seen_r;
            diff_nxt   = {s_in[sgf_pkg::VAL_W-1], s_in} - {last_r[sgf_pkg::VAL_W-1], last_r};
            prod_nxt   = sgf_pkg::PROD_W'(diff_nxt);
            if (pend_r == '0) begin
              state_nxt = S_SAMPLE;
            end else if (seen_r) begin
              state_nxt = S_DSTART;
            end else begin
              state_nxt = S_WAIT;
            end
            if (in_tlast) begin
              last_nxt = '0;
              seen_nxt = 1'b0;
            end else begin
              last_nxt = s_in;
              seen_nxt = 1'b1;
            end
            pend_nxt = '0;
          end
        end
      end
      S_DSTART: begin
        div_req.start = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        if (div_rsp.done) begin
          val_nxt   = interp_sum[sgf_pkg::VAL_W-1:0];
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        if (out_free) begin
          ov_nxt     = 1'b1;
          ovalue_nxt = val_r;
          ofill_nxt  = 1'b1;
          oovf_nxt   = ovf_r;
          orl_nxt    = fill_last;
          osl_nxt    = fill_last & end_r;
          if (k_r == nfill_r) begin
            state_nxt = smp_r ? S_SAMPLE : S_IDLE;
          end else begin
            k_nxt     = k_r + 1'b1;
            prod_nxt  = prod_r + sgf_pkg::PROD_W'(diff_r);
            state_nxt = interp_r ? S_DSTART : S_WAIT;
          end
        end
      end
      S_SAMPLE: begin
        if (out_free) begin
          ov_nxt     = 1'b1;
          ovalue_nxt = s_r;
          ofill_nxt  = 1'b0;
          oovf_nxt   = 1'b0;
          orl_nxt    = 1'b1;
          osl_nxt    = end_r;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      last_r  <= '0;
      seen_r  <= 1'b0;
      pend_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      last_r  <= last_nxt;
      seen_r  <= seen_nxt;
      pend_r  <= pend_nxt;
      ov_r    <= ov_nxt;
    end
    s_r      <= s_nxt;
    base_r   <= base_nxt;
    val_r    <= val_nxt;
    diff_r   <= diff_nxt;
    prod_r   <= prod_nxt;
    den_r    <= den_nxt;
    k_r      <= k_nxt;
    nfill_r  <= nfill_nxt;
    interp_r <= interp_nxt;
    smp_r    <= smp_nxt;
    ovf_r    <= ovf_nxt;
    end_r    <= end_nxt;
    ovalue_r <= ovalue_nxt;
    ofill_r  <= ofill_nxt;
    oovf_r   <= oovf_nxt;
    orl_r    <= orl_nxt;
    osl_r    <= osl_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = ovalue_r;
  assign out_tuser  = {osl_r, oovf_r, ofill_r};
  assign out_tlast  = orl_r;

endmodule

@@ rtl/sgf_chk.sv @@
module sgf_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic [2:0]  out_tuser,
  input logic        out_tlast
);

  // stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("out item changed under stall");

  // a valid sample always produces at least one item, so the block goes busy
  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser |=> !in_tready)
    else $error("valid sample accepted without going busy");

  // the sample itself closes its run
  a_sample_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tlast && !out_tuser[1])
    else $error("unfilled item not last of run, or flagged overflow");

  // series end only on a run's last item
  a_series_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2] |-> out_tlast)
    else $error("series_last without run_last");

  // overflow flush never ends the series
  a_ovf_series: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> !out_tuser[2])
    else $error("overflow hold marked series_last");

endmodule

bind series_gap_linear_fill sgf_chk u_sgf_chk (.*);
